@@ sv/bcg_pkg.sv @@
// bcg_pkg: shared constants and the cell voltage breakpoint table
// for the battery charge gauge; no dependencies
`default_nettype none

package bcg_pkg;

    localparam int unsigned TABLE_SLOTS  = 32;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned MV_W         = 13;
    localparam int unsigned CHG_W        = 14;
    localparam int unsigned DEN_W        = 10;
    localparam int unsigned NUM_W        = 24;
    localparam int unsigned QCNT_W       = 4;
    localparam int unsigned SEGMENTS_DEF = 20;
    localparam int unsigned FULL_CENTI   = 10000;

    localparam logic [CHG_W-1:0] THR_HIGH = CHG_W'(7500);
    localparam logic [CHG_W-1:0] THR_MID  = CHG_W'(5000);
    localparam logic [CHG_W-1:0] THR_LOW  = CHG_W'(2500);

    // descending breakpoints in mV, padded with the bottom voltage
    function automatic logic [MV_W-1:0] volt_mv(input logic [IDX_W-1:0] idx);
        logic [MV_W-1:0] mv;
        case (idx)
            5'd0:    mv = MV_W'(4200);
            5'd1:    mv = MV_W'(4150);
            5'd2:    mv = MV_W'(4110);
            5'd3:    mv = MV_W'(4080);
            5'd4:    mv = MV_W'(4020);
            5'd5:    mv = MV_W'(3980);
            5'd6:    mv = MV_W'(3950);
            5'd7:    mv = MV_W'(3910);
            5'd8:    mv = MV_W'(3870);
            5'd9:    mv = MV_W'(3850);
            5'd10:   mv = MV_W'(3840);
            5'd11:   mv = MV_W'(3820);
            5'd12:   mv = MV_W'(3800);
            5'd13:   mv = MV_W'(3790);
            5'd14:   mv = MV_W'(3770);
            5'd15:   mv = MV_W'(3750);
            5'd16:   mv = MV_W'(3730);
            5'd17:   mv = MV_W'(3710);
            5'd18:   mv = MV_W'(3690);
            5'd19:   mv = MV_W'(3610);
            default: mv = MV_W'(3270);
        endcase
        return mv;
    endfunction

endpackage

`default_nettype wire

@@ sv/battery_charge_gauge.sv @@
// battery_charge_gauge: clip, serial segment search, shared multiply-add,
// restoring divide; one item in flight. Depends on bcg_pkg.
// Steps: load in IDLE, then a serial search of one breakpoint per cycle in SEARCH,
// multiply-add in MULA and MULB, restoring divide in DIV, output in FIN.
// A new item is taken only when the last one has left FIN; s_ready is high
// only while idle.
// Reset: aresetn synchronous, active low; clears the sequencer and m_valid.
`default_nettype none

module battery_charge_gauge
    import bcg_pkg::*;
#(
    parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [MV_W-1:0]  s_cell_millivolts,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [CHG_W-1:0]      m_charge_centi_percent,
    output logic [1:0]            m_bar_level
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_MULA   = 6'b000100,
        ST_MULB   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    localparam int unsigned SEG_LAST = SEGMENTS - 1;
    localparam logic [MV_W-1:0] V_TOP = volt_mv(IDX_W'(0));
    localparam logic [MV_W-1:0] V_BOT = volt_mv(IDX_W'(SEGMENTS));
    localparam logic [QCNT_W-1:0] QBITS_LAST = QCNT_W'(CHG_W - 1);

    // capacity at each breakpoint, worked out at elaboration
    logic [CHG_W-1:0] cap_tab [TABLE_SLOTS];
    for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cap
        if (k <= SEGMENTS) begin : g_used
            assign cap_tab[k] = CHG_W'(((SEGMENTS - k) * FULL_CENTI) / SEGMENTS);
        end else begin : g_pad
            assign cap_tab[k] = '0;
        end
    end

    state_t              state_reg, state_next;
    logic [MV_W-1:0]     v_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [DEN_W-1:0]    den_reg;
    logic                degen_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    dsh_reg;
    logic [CHG_W-1:0]    q_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                m_valid_reg;
    logic [CHG_W-1:0]    charge_reg;
    logic [1:0]          bar_reg;

    logic [IDX_W-1:0]    i_up;
    logic [MV_W-1:0]     v_hi, v_lo, v_clip;
    logic                found;
    logic [CHG_W-1:0]    mul_a;
    logic [DEN_W-1:0]    mul_b;
    logic [NUM_W-1:0]    prod;
    logic                div_ge;
    logic [NUM_W-1:0]    div_sub;
    logic                rem_nz;
    logic [1:0]          bar_calc;
    logic [CHG_W-1:0]    charge_calc;

    assign i_up  = i_reg + IDX_W'(1);
    assign v_hi  = volt_mv(i_reg);
    assign v_lo  = volt_mv(i_up);
    assign found = (i_reg >= IDX_W'(SEG_LAST)) || (v_reg >= v_lo);

    always_comb begin
        if (s_cell_millivolts > V_TOP) begin
            v_clip = V_TOP;
        end else if (s_cell_millivolts < V_BOT) begin
            v_clip = V_BOT;
        end else begin
            v_clip = s_cell_millivolts;
        end
    end

    // shared multiply-add operands: cap_lo*den, then (cap_hi-cap_lo)*(v-lo); degenerate segment: cap_hi*1, then 0
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MULA) begin
            mul_a = degen_reg ? cap_tab[i_reg] : cap_tab[i_up];
            mul_b = degen_reg ? DEN_W'(1) : den_reg;
        end else if (!degen_reg) begin
            mul_a = cap_tab[i_reg] - cap_tab[i_up];
            mul_b = DEN_W'(v_reg - v_lo);
        end
    end
    assign prod = NUM_W'(mul_a) * NUM_W'(mul_b);

    assign div_ge  = num_reg >= dsh_reg;
    assign div_sub = num_reg - dsh_reg;

    // exact charge above a threshold: quotient above it, or equal with remainder
    assign rem_nz = num_reg != '0;
    always_comb begin
        bar_calc = '0;
        if ((q_reg > THR_HIGH) || ((q_reg == THR_HIGH) && rem_nz)) bar_calc = bar_calc + 2'd1;
        if ((q_reg > THR_MID)  || ((q_reg == THR_MID)  && rem_nz)) bar_calc = bar_calc + 2'd1;
        if ((q_reg > THR_LOW)  || ((q_reg == THR_LOW)  && rem_nz)) bar_calc = bar_calc + 2'd1;
        charge_calc = (q_reg > CHG_W'(FULL_CENTI)) ? CHG_W'(FULL_CENTI) : q_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SEARCH;
            ST_SEARCH: if (found) state_next = ST_MULA;
            ST_MULA:   state_next = ST_MULB;
            ST_MULB:   state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                v_reg <= v_clip;
                i_reg <= '0;
            end
            ST_SEARCH: begin
                if (found) begin
                    degen_reg <= v_hi <= v_lo;
                    den_reg   <= (v_hi <= v_lo) ? DEN_W'(1) : DEN_W'(v_hi - v_lo);
                end else begin
                    i_reg <= i_up;
                end
            end
            ST_MULA: begin
                num_reg <= prod;
            end
            ST_MULB: begin
                num_reg <= num_reg + prod;
                dsh_reg <= NUM_W'(den_reg) << QBITS_LAST;
                cnt_reg <= QBITS_LAST;
            end
            ST_DIV: begin
                if (div_ge) num_reg <= div_sub;
                q_reg   <= {q_reg[CHG_W-2:0], div_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    charge_reg <= charge_calc;
                    bar_reg    <= bar_calc;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready                = state_reg == ST_IDLE;
    assign m_valid                = m_valid_reg;
    assign m_charge_centi_percent = charge_reg;
    assign m_bar_level            = bar_reg;

    a_charge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> charge_reg <= CHG_W'(FULL_CENTI))
        else $error("charge above full scale");

    a_bar_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((bar_reg != 2'd3) || (charge_reg >= THR_HIGH))
                     && ((bar_reg != 2'd0) || (charge_reg <= THR_LOW)))
        else $error("bar level disagrees with charge");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> {1'b0, num_reg} < {dsh_reg, 1'b0})
        else $error("partial remainder out of range");

    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> i_reg <= IDX_W'(SEG_LAST))
        else $error("segment search ran past the table");

endmodule

`default_nettype wire
